FILE: rtl/pcmunp_pkg.sv
`default_nettype none

package pcmunp_pkg;

   localparam int unsigned CSR_INDEX_W = 2;
   localparam int unsigned CSR_DATA_W  = 3;

   localparam logic [CSR_INDEX_W-1:0] REG_SAMPLE_BYTES  = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_CHANNEL_COUNT = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_LITTLE_ENDIAN = 2'd2;

   localparam logic [2:0] SAMPLE_BYTES_RESET  = 3'd2;
   localparam logic [1:0] CHANNEL_COUNT_RESET = 2'd2;

   // Unsigned-to-signed flip for 8-bit little-endian data
   localparam logic [7:0] FLIP_BIT = 8'h80;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       stream_start;
   } req_payload_type;

   typedef struct packed {
      logic signed [31:0] sample_word;
      logic               channel;
      logic               frame_end;
   } rsp_payload_type;

endpackage

`default_nettype wire

FILE: rtl/pcm_byte_to_sample_unpacker_core.sv
`default_nettype none

// PCM byte-to-sample unpacker.
// req_*: one raw PCM byte per word (data_byte, stream_start). A word is taken
//   when req_valid is high and req_stall low. stream_start clears the partial
//   sample and the channel phase before its byte is used.
// rsp_*: one left-justified 32-bit sample per word, with its channel and a
//   frame_end flag on the right-channel word. Mono samples come out twice,
//   left then right.
// csr_*: register writes (index, data), always ready; write only while idle.
// The byte that completes a sample writes its result into the queue when it
//   is taken; rsp_* presents results from the queue head.
// Throughput: one byte per cycle while req_stall is low. Stereo and multi-byte
//   mono keep that rate; 8-bit mono gives two result words per byte, so the
//   output port sets the pace there.
// A four-entry result queue sits between the sides; req_stall is high only
//   when that queue is full, and comes from registers alone.
// rsp_stall holds the current result; the queue then fills and stalls req_*.
// Reset (synchronous) empties the queue, clears the partial sample and
//   phase, and sets 16-bit big-endian stereo.
module pcm_byte_to_sample_unpacker_core
   import pcmunp_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_stall,
   input  wire req_payload_type        req_data,
   output logic                        rsp_valid,
   input  wire logic                   rsp_stall,
   output rsp_payload_type             rsp_data,
   input  wire logic                   csr_valid,
   output logic                        csr_ready,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_data
);

   localparam int unsigned DEPTH = 4;
   localparam int unsigned PTR_W = $clog2(DEPTH);
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);

   typedef struct packed {
      logic [31:0] word;
      logic        channel;
      logic        dup;
   } entry_type;

   logic [2:0]  sample_bytes_ff;
   logic [1:0]  channel_count_ff;
   logic        little_endian_ff;

   logic [23:0] partial_ff, partial_in;
   logic [1:0]  held_ff, held_in;
   logic        phase_ff, phase_in;

   entry_type   entries_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [CNT_W-1:0] count_ff, count_in;
   logic        half_ff, half_in;

   logic [2:0]  size;
   logic [23:0] partial_cur;
   logic [1:0]  held_cur;
   logic        phase_cur;
   logic [31:0] acc;
   logic [31:0] word;
   logic [2:0]  n;
   logic        complete;
   logic        stereo;
   logic        accept;
   logic        push;
   logic        pop;
   entry_type   head;
   entry_type   entry_in;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         sample_bytes_ff  <= SAMPLE_BYTES_RESET;
         channel_count_ff <= CHANNEL_COUNT_RESET;
         little_endian_ff <= 1'b0;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            REG_SAMPLE_BYTES:  sample_bytes_ff  <= csr_data;
            REG_CHANNEL_COUNT: channel_count_ff <= csr_data[1:0];
            REG_LITTLE_ENDIAN: little_endian_ff <= csr_data[0];
            default: ;
         endcase
      end
   end

   // Sample assembly
   always_comb begin
      priority if (sample_bytes_ff == 3'd0) begin
         size = 3'd1;
      end else if (sample_bytes_ff > 3'd4) begin
         size = 3'd4;
      end else begin
         size = sample_bytes_ff;
      end

      partial_cur = req_data.stream_start ? 24'd0 : partial_ff;
      held_cur    = req_data.stream_start ? 2'd0  : held_ff;
      phase_cur   = req_data.stream_start ? 1'b0  : phase_ff;

      if (little_endian_ff) begin
         acc = {8'd0, partial_cur} | ({24'd0, req_data.data_byte} << {held_cur, 3'b000});
      end else begin
         acc = {partial_cur, req_data.data_byte};
      end

      n        = {1'b0, held_cur} + 3'd1;
      complete = (n >= size);
      stereo   = channel_count_ff[1];

      unique case (held_cur)
         2'd0:    word = {acc[7:0], 24'd0};
         2'd1:    word = {acc[15:0], 16'd0};
         2'd2:    word = {acc[23:0], 8'd0};
         default: word = acc;
      endcase
      if (size == 3'd1 && little_endian_ff) begin
         word[31:24] = word[31:24] ^ FLIP_BIT;
      end

      entry_in.word    = word;
      entry_in.channel = phase_cur;
      entry_in.dup     = !stereo;

      partial_in = partial_ff;
      held_in    = held_ff;
      phase_in   = phase_ff;
      if (accept) begin
         if (complete) begin
            partial_in = 24'd0;
            held_in    = 2'd0;
            phase_in   = stereo ? !phase_cur : 1'b0;
         end else begin
            partial_in = acc[23:0];
            held_in    = n[1:0];
            phase_in   = phase_cur;
         end
      end
   end

   // Result queue; a mono entry goes out twice, left then right
   assign req_stall = (count_ff == CNT_W'(DEPTH));
   assign accept    = req_valid && !req_stall;
   assign push      = accept && complete;
   assign head      = entries_ff[rd_ptr_ff];
   assign rsp_valid = (count_ff != '0);
   assign pop       = rsp_valid && !rsp_stall && (!head.dup || half_ff);

   always_comb begin
      count_in = count_ff + CNT_W'(push) - CNT_W'(pop);
      half_in  = half_ff;
      if (rsp_valid && !rsp_stall && head.dup) begin
         half_in = !half_ff;
      end

      rsp_data.sample_word = head.word;
      rsp_data.channel     = head.dup ? half_ff : head.channel;
      rsp_data.frame_end   = head.dup ? half_ff : head.channel;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         partial_ff <= '0;
         held_ff    <= '0;
         phase_ff   <= 1'b0;
         wr_ptr_ff  <= '0;
         rd_ptr_ff  <= '0;
         count_ff   <= '0;
         half_ff    <= 1'b0;
      end else begin
         partial_ff <= partial_in;
         held_ff    <= held_in;
         phase_ff   <= phase_in;
         count_ff   <= count_in;
         half_ff    <= half_in;
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + PTR_W'(1);
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + PTR_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= entry_in;
      end
   end

`ifndef ASSERT_OFF
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("result queue count beyond depth");

   a_half_on_dup: assert property (@(posedge clock) disable iff (reset)
      half_ff |-> (rsp_valid && head.dup))
      else $error("second half of duplicate without a mono entry at head");

   a_dup_second: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_stall && head.dup && !half_ff) |=>
         (rsp_valid && rsp_data.channel && $stable(rsp_data.sample_word)))
      else $error("mono duplicate did not follow on the right channel");
`endif

endmodule

`default_nettype wire
